// ===== rtl/ssdiv_pkg.sv =====
// shared types for the signed shift-subtract divider
// state encoding of the top-level sequencer and the control/status structs to the core
// no dependencies
package ssdiv_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_FIX
   } state_type;

   typedef struct packed {
      logic start;
   } core_ctrl_type;

   typedef struct packed {
      logic busy;
      logic last;
   } core_status_type;

endpackage

// ===== rtl/ssdiv_core.sv =====
// radix-2 restoring division of two unsigned magnitudes, one quotient bit per cycle
// the dividend shifts out of the top of one register while quotient bits shift in below
// depends on ssdiv_pkg
module ssdiv_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ssdiv_pkg::core_ctrl_type  ctrl,
   input  logic [DATA_WIDTH-1:0]     dividend_mag,
   input  logic [DATA_WIDTH-1:0]     divisor_mag,
   output ssdiv_pkg::core_status_type status,
   output logic [DATA_WIDTH-1:0]     quotient_mag
);

   localparam int CountWidth = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] shift_ff;
   logic [DATA_WIDTH-1:0] shift_in;
   logic [DATA_WIDTH-1:0] divisor_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic [DATA_WIDTH-1:0] trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   logic                  busy;

   assign busy  = (count_ff != '0);
   // partial remainder stays below the divisor, so one shifted bit still fits in DATA_WIDTH
   assign trial = {rem_ff[DATA_WIDTH-2:0], shift_ff[DATA_WIDTH-1]};
   assign diff  = {1'b0, trial} - {1'b0, divisor_ff};
   assign fits  = ~diff[DATA_WIDTH];

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      if (ctrl.start) begin
         rem_in   = '0;
         shift_in = dividend_mag;
         count_in = CountWidth'(DATA_WIDTH);
      end else if (busy) begin
         rem_in   = fits ? diff[DATA_WIDTH-1:0] : trial;
         shift_in = {shift_ff[DATA_WIDTH-2:0], fits};
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      if (ctrl.start) begin
         divisor_ff <= divisor_mag;
      end
   end

   assign status.busy  = busy;
   assign status.last  = (count_ff == CountWidth'(1));
   assign quotient_mag = shift_ff;

endmodule

// ===== rtl/signed_shift_subtract_divider.sv =====
// signed divider: an accepted request passes through the setup state (magnitudes and sign),
// the DATA_WIDTH iterations of the shift-subtract core, and the fix-up state, before the result is valid
// a new request is taken only in the idle state, after the fix-up has loaded the output register
// a finished result waits in the output register while the next item is taken
// synchronous active-high reset clears the sequencer and the result valid
// depends on ssdiv_pkg and ssdiv_core
module signed_shift_subtract_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_dividend,
   input  logic signed [DATA_WIDTH-1:0] req_divisor,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_quotient,
   output logic                         rsp_divide_by_zero
);

   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   ssdiv_pkg::state_type       state_ff;
   ssdiv_pkg::state_type       state_in;
   ssdiv_pkg::core_ctrl_type   core_ctrl;
   ssdiv_pkg::core_status_type core_status;

   logic [DATA_WIDTH-1:0] dividend_ff;
   logic [DATA_WIDTH-1:0] divisor_ff;
   logic                  positive_ff;
   logic                  zero_div_ff;
   logic                  positive_in;
   logic                  zero_div_in;
   logic [DATA_WIDTH-1:0] dividend_mag;
   logic [DATA_WIDTH-1:0] divisor_mag;
   logic [DATA_WIDTH-1:0] quotient_mag;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_quotient_ff;
   logic [DATA_WIDTH-1:0] rsp_quotient_in;
   logic                  rsp_zero_ff;
   logic                  rsp_zero_in;

   logic accept;
   logic out_free;
   logic load_result;

   assign accept   = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssdiv_pkg::ST_IDLE: begin
            if (accept) state_in = ssdiv_pkg::ST_SETUP;
         end
         ssdiv_pkg::ST_SETUP: begin
            state_in = ssdiv_pkg::ST_RUN;
         end
         ssdiv_pkg::ST_RUN: begin
            if (core_status.last) state_in = ssdiv_pkg::ST_FIX;
         end
         ssdiv_pkg::ST_FIX: begin
            if (out_free) state_in = ssdiv_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssdiv_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall       = 1'b1;
      core_ctrl.start = 1'b0;
      load_result     = 1'b0;
      case (state_ff)
         ssdiv_pkg::ST_IDLE:  req_stall       = 1'b0;
         ssdiv_pkg::ST_SETUP: core_ctrl.start = 1'b1;
         ssdiv_pkg::ST_RUN:   req_stall       = 1'b1;
         ssdiv_pkg::ST_FIX:   load_result     = out_free;
         default:             req_stall       = 1'b1;
      endcase
   end

   // magnitudes and sign of the result from the captured operands
   always_comb begin
      dividend_mag = dividend_ff[DATA_WIDTH-1] ? (~dividend_ff + 1'b1) : dividend_ff;
      divisor_mag  = divisor_ff[DATA_WIDTH-1]  ? (~divisor_ff + 1'b1)  : divisor_ff;
      positive_in  = (dividend_ff == '0) |
                     (dividend_ff[DATA_WIDTH-1] == divisor_ff[DATA_WIDTH-1]);
      zero_div_in  = (divisor_ff == '0);
   end

   ssdiv_core #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (core_ctrl),
      .dividend_mag(dividend_mag),
      .divisor_mag (divisor_mag),
      .status      (core_status),
      .quotient_mag(quotient_mag)
   );

   // sign fix-up with saturation of a full-scale magnitude, and a zero quotient on divide by zero
   always_comb begin
      rsp_zero_in = zero_div_ff;
      if (zero_div_ff) begin
         rsp_quotient_in = '0;
      end else if (quotient_mag[DATA_WIDTH-1]) begin
         rsp_quotient_in = positive_ff ? MaxPos : MinNeg;
      end else if (positive_ff) begin
         rsp_quotient_in = quotient_mag;
      end else begin
         rsp_quotient_in = ~quotient_mag + 1'b1;
      end
   end

   assign rsp_valid_in = load_result | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssdiv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dividend_ff <= req_dividend;
         divisor_ff  <= req_divisor;
      end
      if (core_ctrl.start) begin
         positive_ff <= positive_in;
         zero_div_ff <= zero_div_in;
      end
      if (load_result) begin
         rsp_quotient_ff <= rsp_quotient_in;
         rsp_zero_ff     <= rsp_zero_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quotient_ff;
   assign rsp_divide_by_zero = rsp_zero_ff;

endmodule
